>>> sv/als_ag_pkg.sv
package als_ag_pkg;

   // field widths
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned VALUE_W = 23;
   localparam int unsigned LEVEL_W = 2;

   // threshold reset values
   localparam logic [COUNT_W-1:0] UPPER_THRESHOLD_RST = 16'd64000;
   localparam logic [COUNT_W-1:0] LOWER_THRESHOLD_RST = 16'd3000;

   // gain levels
   localparam logic [LEVEL_W-1:0] GAIN_X128 = 2'd0;
   localparam logic [LEVEL_W-1:0] GAIN_X16  = 2'd1;
   localparam logic [LEVEL_W-1:0] GAIN_X1   = 2'd2;

   // normalisation shifts for the lower gains
   localparam int unsigned SHIFT_X16 = 3;
   localparam int unsigned SHIFT_X1  = 7;

   // word kinds
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // register indexes
   localparam logic CSR_UPPER_THRESHOLD = 1'b0;
   localparam logic CSR_LOWER_THRESHOLD = 1'b1;

endpackage

>>> sv/als_auto_gain_moving_average_top.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req_kind, req_data_ready, req_light_count,
//                                              req_clear_count
// rsp       out        rsp_valid / rsp_ready   rsp_filtered_value, rsp_gain_level,
//                                              rsp_gain_changed
// csr       in         csr_wr_en (no wait)     csr_index, csr_wr_data
//
// one word accepted per cycle unless the output stalls; ranging, filter state and the
// window sum update in the accept cycle; the averaging divide is a shift for a
// power-of-two WINDOW, else a reciprocal multiply over the two following stages
// the three stages move together: a stalled result holds the whole pipe
// synchronous reset; window entries are tracked by the fill count, no clearing pass
module als_auto_gain_moving_average_top
   import als_ag_pkg::*;
#(
   parameter int unsigned WINDOW = 8
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic                 req_data_ready,
   input  logic [COUNT_W-1:0]   req_light_count,
   input  logic [COUNT_W-1:0]   req_clear_count,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VALUE_W-1:0]   rsp_filtered_value,
   output logic [LEVEL_W-1:0]   rsp_gain_level,
   output logic                 rsp_gain_changed,

   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [COUNT_W-1:0]   csr_wr_data
);

   localparam int unsigned LOG_W  = $clog2(WINDOW);
   localparam int unsigned SLOT_W = LOG_W;
   localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
   localparam int unsigned SUM_W  = VALUE_W + LOG_W;
   localparam bit          POW2   = ((WINDOW & (WINDOW - 1)) == 0);

   // configuration
   logic [COUNT_W-1:0] upper_ff, upper_in;
   logic [COUNT_W-1:0] lower_ff, lower_in;

   // ranging and filter state
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               first_ff, first_in;
   logic [VALUE_W-1:0] held_ff, held_in;
   logic [VALUE_W-1:0] window_ff [WINDOW];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   // stage 1: value, new sum and result fields
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_avg_ff, s1_avg_in;
   logic [VALUE_W-1:0] s1_raw_ff, s1_raw_in;
   logic [SUM_W-1:0]   s1_sum_ff, s1_sum_in;
   logic [LEVEL_W-1:0] s1_level_ff, s1_level_in;
   logic               s1_changed_ff, s1_changed_in;

   // stage 2: quotient in progress
   logic               s2_valid_ff;
   logic               s2_avg_ff;
   logic [VALUE_W-1:0] s2_raw_ff;
   logic [LEVEL_W-1:0] s2_level_ff;
   logic               s2_changed_ff;
   logic [VALUE_W-1:0] s2_avg_value;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_changed_ff;

   logic               advance;
   logic               accept;
   logic               take_sample;
   logic               take_restart;
   logic               above;
   logic               below;
   logic               changed;
   logic               full;
   logic               store_we;
   logic [VALUE_W-1:0] value;
   logic [VALUE_W-1:0] norm;
   logic [VALUE_W-1:0] oldest;

   // whole pipe moves when the output register is free or being drained
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign req_ready    = advance;
   assign accept       = req_valid && req_ready;
   assign take_sample  = accept && (req_kind == KIND_SAMPLE) && req_data_ready;
   assign take_restart = accept && (req_kind == KIND_RESTART);

   // either channel over the upper threshold, or both under the lower one
   assign above = (req_light_count > upper_ff) || (req_clear_count > upper_ff);
   assign below = (req_light_count < lower_ff) && (req_clear_count < lower_ff);

   assign full   = (fill_ff == CNT_W'(WINDOW));
   assign oldest = window_ff[slot_ff];

   // light scaled by 128/gain at the current level
   always_comb begin
      unique case (level_ff)
         GAIN_X128: norm = VALUE_W'(req_light_count);
         GAIN_X16:  norm = VALUE_W'(req_light_count) << SHIFT_X16;
         GAIN_X1:   norm = VALUE_W'(req_light_count) << SHIFT_X1;
         default:   norm = VALUE_W'(req_light_count) << SHIFT_X1;
      endcase
   end

   // configuration writes
   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UPPER_THRESHOLD: upper_in = csr_wr_data;
            CSR_LOWER_THRESHOLD: lower_in = csr_wr_data;
            default:             upper_in = upper_ff;
         endcase
      end
   end

   // ranging and filter update for the accepted word
   always_comb begin
      level_in      = level_ff;
      first_in      = first_ff;
      held_in       = held_ff;
      sum_in        = sum_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      changed       = 1'b0;
      store_we      = 1'b0;
      value         = norm;
      s1_valid_in   = 1'b0;
      s1_avg_in     = full;
      s1_level_in   = level_ff;

      if (take_restart) begin
         first_in = 1'b1;
         sum_in   = '0;
         fill_in  = '0;
         slot_in  = '0;
      end else if (take_sample) begin
         if (first_ff) begin
            first_in = 1'b0;
         end else if (above && (level_ff != GAIN_X1)) begin
            level_in = level_ff + LEVEL_W'(1);
            changed  = 1'b1;
         end else if (below && (level_ff != GAIN_X128)) begin
            level_in = level_ff - LEVEL_W'(1);
            changed  = 1'b1;
         end
         // on a gain step the last value stands in for this one
         value   = changed ? held_ff : norm;
         held_in = value;

         store_we = 1'b1;
         if (full) begin
            sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(value);
         end else begin
            sum_in  = sum_ff + SUM_W'(value);
            fill_in = fill_ff + CNT_W'(1);
         end
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);

         s1_valid_in = 1'b1;
         s1_level_in = level_in;
      end
   end

   assign s1_raw_in     = value;
   assign s1_sum_in     = sum_in;
   assign s1_changed_in = changed;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UPPER_THRESHOLD_RST;
         lower_ff <= LOWER_THRESHOLD_RST;
         level_ff <= GAIN_X128;
         first_ff <= 1'b1;
         held_ff  <= '0;
         sum_ff   <= '0;
         fill_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
         level_ff <= level_in;
         first_ff <= first_in;
         held_ff  <= held_in;
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
      end
   end

   // window entries, valid up to the fill count
   always_ff @(posedge clock) begin
      if (store_we) begin
         window_ff[slot_ff] <= value;
      end
   end

   // stage 1 and stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_avg_ff     <= s1_avg_in;
         s1_raw_ff     <= s1_raw_in;
         s1_sum_ff     <= s1_sum_in;
         s1_level_ff   <= s1_level_in;
         s1_changed_ff <= s1_changed_in;
         s2_avg_ff     <= s1_avg_ff;
         s2_raw_ff     <= s1_raw_ff;
         s2_level_ff   <= s1_level_ff;
         s2_changed_ff <= s1_changed_ff;
      end
   end

   // sum / WINDOW, truncated
   generate
      if (POW2) begin : g_shift
         logic [SUM_W-1:0] sum2_ff;

         always_ff @(posedge clock) begin
            if (advance) begin
               sum2_ff <= s1_sum_ff;
            end
         end

         assign s2_avg_value = VALUE_W'(sum2_ff >> LOG_W);
      end else begin : g_recip
         // floor(s * M / 2^K) equals floor(s / WINDOW) for every sum in range
         localparam int unsigned K      = SUM_W + LOG_W;
         localparam int unsigned M_W    = SUM_W + 1;
         localparam logic [63:0] M_FULL = ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
         localparam logic [M_W-1:0] M   = M_FULL[M_W-1:0];
         localparam int unsigned LO_W   = SUM_W / 2;
         localparam int unsigned HI_W   = SUM_W - LO_W;
         localparam int unsigned PROD_W = SUM_W + M_W;

         logic [LO_W+M_W-1:0] pp_lo_ff;
         logic [HI_W+M_W-1:0] pp_hi_ff;
         logic [PROD_W-1:0]   prod;

         // partial products on the two halves of the sum
         always_ff @(posedge clock) begin
            if (advance) begin
               pp_lo_ff <= (LO_W+M_W)'(s1_sum_ff[LO_W-1:0]) * (LO_W+M_W)'(M);
               pp_hi_ff <= (HI_W+M_W)'(s1_sum_ff[SUM_W-1:LO_W]) * (HI_W+M_W)'(M);
            end
         end

         assign prod         = (PROD_W'(pp_hi_ff) << LO_W) + PROD_W'(pp_lo_ff);
         assign s2_avg_value = prod[K+VALUE_W-1:K];
      end
   endgenerate

   // output register
   assign rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;
   assign rsp_value_in = s2_avg_ff ? s2_avg_value : s2_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff   <= rsp_value_in;
         rsp_level_ff   <= s2_level_ff;
         rsp_changed_ff <= s2_changed_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_gain_level     = rsp_level_ff;
   assign rsp_gain_changed   = rsp_changed_ff;

endmodule
